// ----- src/binary_trie_longest_prefix_match_core_macros.svh -----
// assertion macros for the trie route table core
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define BTLPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define BTLPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/btlpm_pkg.sv -----
// shared types and constants for the trie route table core
`default_nettype none

package btlpm_pkg;

	localparam int NODE_COUNT_DEF   = 1024;
	localparam int ADDRESS_BITS_DEF = 32;
	localparam int FIELD_W          = 32;
	localparam int LEN_W            = 6;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_ALLOC,
		ST_FETCH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic zero_we;
		logic one_we;
		logic flag_we;
	} node_we_t;

	typedef struct packed {
		logic [FIELD_W-1:0] prefix;
		logic [LEN_W-1:0]   length;
		logic [FIELD_W-1:0] tag;
	} route_t;

endpackage

`default_nettype wire

// ----- src/btlpm_req_if.sv -----
// request channel: lookup or insert item
`default_nettype none

interface btlpm_req_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [btlpm_pkg::FIELD_W-1:0]     route_address;
	logic [btlpm_pkg::LEN_W-1:0]       route_length;
	logic [btlpm_pkg::FIELD_W-1:0]     route_tag;

	modport source (
		output valid, opcode, route_address, route_length, route_tag,
		input  ready
	);

	modport sink (
		input  valid, opcode, route_address, route_length, route_tag,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/btlpm_rsp_if.sv -----
// response channel: match or insert status item
`default_nettype none

interface btlpm_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [btlpm_pkg::FIELD_W-1:0]     matched_prefix;
	logic [btlpm_pkg::LEN_W-1:0]       matched_length;
	logic [btlpm_pkg::FIELD_W-1:0]     matched_tag;
	logic                              pool_full;

	modport source (
		output valid, found, matched_prefix, matched_length, matched_tag, pool_full,
		input  ready
	);

	modport sink (
		input  valid, found, matched_prefix, matched_length, matched_tag, pool_full,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/binary_trie_longest_prefix_match_core.sv -----
// top level of the binary trie longest prefix match route table
// lookup: one node memory read per address bit, at most ADDRESS_BITS (32) levels deep;
// insert: walks the existing path, then allocates one node per bit left; default insert
// skips the walk; results sit in an output register so a new item is taken while one waits
// reset clears control, root links, free count and default flag; memories need no clearing
`default_nettype none
`include "binary_trie_longest_prefix_match_core_macros.svh"

module binary_trie_longest_prefix_match_core #(
	parameter int NODE_COUNT   = btlpm_pkg::NODE_COUNT_DEF,
	parameter int ADDRESS_BITS = btlpm_pkg::ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	btlpm_req_if.sink   req,
	btlpm_rsp_if.source rsp
);

	localparam int NW  = $clog2(NODE_COUNT);
	localparam int CW  = NW + 1;
	localparam int SW  = CW + 1;
	localparam int LVW = $clog2(ADDRESS_BITS + 1);
	localparam int FW  = btlpm_pkg::FIELD_W;
	localparam int LW  = btlpm_pkg::LEN_W;

	localparam logic [LW-1:0]  LEN_MAX      = LW'(ADDRESS_BITS);
	localparam logic [LVW-1:0] LVL_MAX      = LVW'(ADDRESS_BITS);
	localparam logic [CW-1:0]  POOL_END     = CW'(NODE_COUNT);
	localparam logic [SW-1:0]  POOL_SUM_END = SW'(NODE_COUNT);

	btlpm_pkg::state_t  state_q, state_d;
	btlpm_pkg::opcode_t op_q;

	logic [ADDRESS_BITS-1:0] addr_sh_q, addr_q, def_prefix_q;
	logic [LVW-1:0]          len_q, lvl_q;
	logic [FW-1:0]           tag_q, def_tag_q;
	logic [NW-1:0]           node_q, best_q, root_zero_q, root_one_q;
	logic                    hit_q, refuse_q, def_valid_q;
	logic [CW-1:0]           next_free_q;

	logic                    rsp_valid_q, found_q, full_q;
	logic [FW-1:0]           mprefix_q, mtag_q;
	logic [LW-1:0]           mlen_q;

	// datapath helpers
	logic                    req_fire, req_default, bit_cur, at_root, walk_stop, hr_hit;
	logic                    link_go, shift_en, alloc_last, short_pool, rsp_load;
	logic [ADDRESS_BITS-1:0] addr_in;
	logic [LW-1:0]           len_sat;
	logic [LVW-1:0]          needed;
	logic [NW-1:0]           child, new_c, c_next;

	// memory ports
	btlpm_pkg::node_we_t node_we;
	logic [NW-1:0]       node_waddr, zero_wd, one_wd, zero_rd, one_rd;
	logic                flag_wd, flag_rd;
	logic                route_we;
	logic [NW-1:0]       route_waddr;
	btlpm_pkg::route_t   route_wd, route_rd;

	assign req.ready   = (state_q == btlpm_pkg::ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign addr_in     = req.route_address[ADDRESS_BITS-1:0];
	assign len_sat     = (req.route_length > LEN_MAX) ? LEN_MAX : req.route_length;
	assign req_default = (req.opcode == btlpm_pkg::OP_INSERT) && (len_sat == '0);

	assign bit_cur = addr_sh_q[ADDRESS_BITS-1];
	assign at_root = (lvl_q == '0);
	// root links live in flops, deeper links come from the node memory read
	assign child   = at_root ? (bit_cur ? root_one_q : root_zero_q)
	                         : (bit_cur ? one_rd : zero_rd);

	assign walk_stop = (child == '0) ||
		((op_q == btlpm_pkg::OP_INSERT) ? (lvl_q == len_q) : (lvl_q == LVL_MAX));
	assign hr_hit    = (state_q == btlpm_pkg::ST_WALK) && (op_q == btlpm_pkg::OP_LOOKUP) &&
		!at_root && flag_rd;

	assign needed     = len_q - lvl_q;
	assign short_pool = (SW'(needed) + SW'(next_free_q)) > POOL_SUM_END;
	assign new_c      = next_free_q[NW-1:0];
	assign c_next     = new_c + NW'(1);
	assign alloc_last = (lvl_q == len_q);

	assign link_go  = (state_q == btlpm_pkg::ST_WALK) && walk_stop &&
		(op_q == btlpm_pkg::OP_INSERT) && !short_pool && (lvl_q != len_q);
	assign shift_en = ((state_q == btlpm_pkg::ST_WALK) && !walk_stop) || link_go ||
		((state_q == btlpm_pkg::ST_ALLOC) && !alloc_last);

	assign rsp_load = (state_q == btlpm_pkg::ST_RESULT) && (!rsp_valid_q || rsp.ready);

	assign route_wd.prefix = FW'(addr_q);
	assign route_wd.length = LW'(len_q);
	assign route_wd.tag    = tag_q;

	btlpm_node_mem #(
		.NODE_COUNT (NODE_COUNT)
	) u_node_mem (
		.clk     (clk),
		.we      (node_we),
		.waddr   (node_waddr),
		.zero_wd (zero_wd),
		.one_wd  (one_wd),
		.flag_wd (flag_wd),
		.raddr   (child),
		.zero_rd (zero_rd),
		.one_rd  (one_rd),
		.flag_rd (flag_rd)
	);

	btlpm_route_mem #(
		.NODE_COUNT (NODE_COUNT)
	) u_route_mem (
		.clk   (clk),
		.we    (route_we),
		.waddr (route_waddr),
		.wd    (route_wd),
		.raddr (best_q),
		.rd    (route_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btlpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		node_we     = '0;
		node_waddr  = node_q;
		zero_wd     = new_c;
		one_wd      = new_c;
		flag_wd     = 1'b0;
		route_we    = 1'b0;
		route_waddr = node_q;
		unique case (state_q)
			btlpm_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = req_default ? btlpm_pkg::ST_RESULT : btlpm_pkg::ST_WALK;
				end
			end
			btlpm_pkg::ST_WALK: begin
				if (walk_stop) begin
					if (op_q == btlpm_pkg::OP_LOOKUP) begin
						state_d = btlpm_pkg::ST_FETCH;
					end else if (short_pool) begin
						state_d = btlpm_pkg::ST_RESULT;
					end else if (lvl_q == len_q) begin
						// path already there, only the route changes
						node_we.flag_we = 1'b1;
						flag_wd         = 1'b1;
						route_we        = 1'b1;
						state_d         = btlpm_pkg::ST_RESULT;
					end else begin
						// hang the first new node off the deepest existing one
						node_we.zero_we = !at_root && !bit_cur;
						node_we.one_we  = !at_root && bit_cur;
						state_d         = btlpm_pkg::ST_ALLOC;
					end
				end
			end
			btlpm_pkg::ST_ALLOC: begin
				// each new node links straight to the one allocated next cycle
				node_we     = '{zero_we: 1'b1, one_we: 1'b1, flag_we: 1'b1};
				node_waddr  = new_c;
				route_waddr = new_c;
				zero_wd     = (!alloc_last && !bit_cur) ? c_next : '0;
				one_wd      = (!alloc_last && bit_cur) ? c_next : '0;
				flag_wd     = alloc_last;
				route_we    = alloc_last;
				if (alloc_last) begin
					state_d = btlpm_pkg::ST_RESULT;
				end
			end
			btlpm_pkg::ST_FETCH: begin
				state_d = btlpm_pkg::ST_RESULT;
			end
			btlpm_pkg::ST_RESULT: begin
				if (rsp_load) begin
					state_d = btlpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btlpm_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= btlpm_pkg::OP_LOOKUP;
			lvl_q       <= '0;
			node_q      <= '0;
			hit_q       <= 1'b0;
			refuse_q    <= 1'b0;
			next_free_q <= CW'(1);
			root_zero_q <= '0;
			root_one_q  <= '0;
			def_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				op_q     <= btlpm_pkg::opcode_t'(req.opcode);
				lvl_q    <= '0;
				node_q   <= '0;
				hit_q    <= 1'b0;
				refuse_q <= 1'b0;
				if (req_default) begin
					def_valid_q <= 1'b1;
				end
			end
			if (shift_en) begin
				lvl_q <= lvl_q + LVW'(1);
			end
			if ((state_q == btlpm_pkg::ST_WALK) && !walk_stop) begin
				node_q <= child;
			end
			if (hr_hit) begin
				hit_q <= 1'b1;
			end
			if ((state_q == btlpm_pkg::ST_WALK) && walk_stop &&
				(op_q == btlpm_pkg::OP_INSERT) && short_pool) begin
				refuse_q <= 1'b1;
			end
			if (link_go && at_root) begin
				if (bit_cur) begin
					root_one_q <= new_c;
				end else begin
					root_zero_q <= new_c;
				end
			end
			if (state_q == btlpm_pkg::ST_ALLOC) begin
				next_free_q <= next_free_q + CW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			addr_sh_q <= addr_in;
			addr_q    <= addr_in;
			tag_q     <= req.route_tag;
			len_q     <= LVW'(len_sat);
			if (req_default) begin
				def_prefix_q <= addr_in;
				def_tag_q    <= req.route_tag;
			end
		end else if (shift_en) begin
			addr_sh_q <= addr_sh_q << 1;
		end
		if (hr_hit) begin
			best_q <= node_q;
		end
		if (rsp_load) begin
			if (op_q == btlpm_pkg::OP_INSERT) begin
				found_q   <= !refuse_q;
				full_q    <= refuse_q;
				mprefix_q <= '0;
				mlen_q    <= '0;
				mtag_q    <= '0;
			end else if (hit_q) begin
				found_q   <= 1'b1;
				full_q    <= 1'b0;
				mprefix_q <= route_rd.prefix;
				mlen_q    <= route_rd.length;
				mtag_q    <= route_rd.tag;
			end else begin
				found_q   <= def_valid_q;
				full_q    <= 1'b0;
				mprefix_q <= def_valid_q ? FW'(def_prefix_q) : '0;
				mlen_q    <= '0;
				mtag_q    <= def_valid_q ? def_tag_q : '0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.found          = found_q;
	assign rsp.matched_prefix = mprefix_q;
	assign rsp.matched_length = mlen_q;
	assign rsp.matched_tag    = mtag_q;
	assign rsp.pool_full      = full_q;

	`BTLPM_ASSERT_NOW(a_alloc_in_pool, state_q == btlpm_pkg::ST_ALLOC, next_free_q < POOL_END, "node allocation ran past the end of the pool")
	`BTLPM_ASSERT_NOW(a_walk_depth, state_q == btlpm_pkg::ST_WALK, lvl_q <= LVL_MAX, "trie walk went deeper than the address width")
	`BTLPM_ASSERT_NOW(a_lookup_not_refused, (state_q == btlpm_pkg::ST_RESULT) && (op_q == btlpm_pkg::OP_LOOKUP), !refuse_q, "lookup item carries a refused insert flag")
	`BTLPM_ASSERT_NEXT(a_result_waits, (state_q == btlpm_pkg::ST_RESULT) && rsp_valid_q && !rsp.ready, (state_q == btlpm_pkg::ST_RESULT) && rsp_valid_q, "pending result item overwritten")

endmodule

`default_nettype wire

// ----- src/btlpm_node_mem.sv -----
// trie node memory: zero child, one child and route flag per node
`default_nettype none

module btlpm_node_mem #(
	parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  btlpm_pkg::node_we_t           we,
	input  logic [$clog2(NODE_COUNT)-1:0] waddr,
	input  logic [$clog2(NODE_COUNT)-1:0] zero_wd,
	input  logic [$clog2(NODE_COUNT)-1:0] one_wd,
	input  logic                          flag_wd,
	input  logic [$clog2(NODE_COUNT)-1:0] raddr,
	output logic [$clog2(NODE_COUNT)-1:0] zero_rd,
	output logic [$clog2(NODE_COUNT)-1:0] one_rd,
	output logic                          flag_rd
);

	localparam int NW = $clog2(NODE_COUNT);

	logic [NW-1:0] zero_mem [NODE_COUNT];
	logic [NW-1:0] one_mem  [NODE_COUNT];
	logic          flag_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (we.zero_we) begin
			zero_mem[waddr] <= zero_wd;
		end
		if (we.one_we) begin
			one_mem[waddr] <= one_wd;
		end
		if (we.flag_we) begin
			flag_mem[waddr] <= flag_wd;
		end
	end

	always_ff @(posedge clk) begin
		zero_rd <= zero_mem[raddr];
		one_rd  <= one_mem[raddr];
		flag_rd <= flag_mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/btlpm_route_mem.sv -----
// route payload memory: prefix, length and tag per node
`default_nettype none

module btlpm_route_mem #(
	parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(NODE_COUNT)-1:0] waddr,
	input  btlpm_pkg::route_t             wd,
	input  logic [$clog2(NODE_COUNT)-1:0] raddr,
	output btlpm_pkg::route_t             rd
);

	btlpm_pkg::route_t route_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			route_mem[waddr] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd <= route_mem[raddr];
	end

endmodule

`default_nettype wire

// ----- verif/btlpm_route_checker.sv -----
// checker for the trie route table: predicts every response item and compares it field by field
`timescale 1ns / 100ps

module btlpm_route_checker
	import btlpm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	btlpm_req_if  req,
	btlpm_rsp_if  rsp,
	output int    failures,
	output int    outstanding
);

	localparam int NODES = NODE_COUNT_DEF;
	localparam int ABITS = ADDRESS_BITS_DEF;
	localparam int IDX_W = $clog2(NODES);
	localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - ABITS);

	typedef struct packed {
		logic   found;
		route_t route;
		logic   pool_full;
	} match_result_t;

	// private copy of the trie, node 0 is the root and child 0 means none
	logic [IDX_W-1:0]   zero_kid  [NODES];
	logic [IDX_W-1:0]   one_kid   [NODES];
	logic               has_route [NODES];
	logic [FIELD_W-1:0] node_pfx  [NODES];
	logic [LEN_W-1:0]   node_len  [NODES];
	logic [FIELD_W-1:0] node_tag  [NODES];
	int unsigned        next_free;
	logic               dflt_valid;
	logic [FIELD_W-1:0] dflt_prefix;
	logic [FIELD_W-1:0] dflt_tag;

	match_result_t pending_matches [$];

	function automatic int unsigned child_of(input int unsigned node, input logic bit_val);
		return bit_val ? 32'(one_kid[node]) : 32'(zero_kid[node]);
	endfunction

	function automatic match_result_t apply_route_op(input opcode_t op,
			input logic [FIELD_W-1:0] addr_in, input logic [LEN_W-1:0] len_in,
			input logic [FIELD_W-1:0] tag);
		match_result_t res;
		logic [FIELD_W-1:0] addr;
		int unsigned len, depth, lvl, node, kid, best;
		logic hit, stop;
		res = '0;
		addr = addr_in & ADDR_MASK;
		node = 0;
		if (op == OP_INSERT) begin
			len = (len_in > LEN_W'(ABITS)) ? 32'(ABITS) : 32'(len_in);
			if (len == 0) begin
				dflt_valid = 1'b1;
				dflt_prefix = addr;
				dflt_tag = tag;
				res.found = 1'b1;
			end else begin
				// follow the part of the path that already exists
				depth = 0;
				while (depth < len && child_of(node, addr[ABITS-1-depth]) != 0) begin
					node = child_of(node, addr[ABITS-1-depth]);
					depth++;
				end
				if (len - depth > NODES - next_free) begin
					res.pool_full = 1'b1;
				end else begin
					for (lvl = depth; lvl < len; lvl++) begin
						kid = next_free;
						next_free++;
						zero_kid[kid] = '0;
						one_kid[kid] = '0;
						has_route[kid] = 1'b0;
						if (addr[ABITS-1-lvl])
							one_kid[node] = kid[IDX_W-1:0];
						else
							zero_kid[node] = kid[IDX_W-1:0];
						node = kid;
					end
					has_route[node] = 1'b1;
					node_pfx[node] = addr;
					node_len[node] = len[LEN_W-1:0];
					node_tag[node] = tag;
					res.found = 1'b1;
				end
			end
		end else begin
			hit = 1'b0;
			best = 0;
			lvl = 0;
			stop = 1'b0;
			while (lvl < ABITS && !stop) begin
				kid = child_of(node, addr[ABITS-1-lvl]);
				if (kid == 0) begin
					stop = 1'b1;
				end else begin
					node = kid;
					if (has_route[node]) begin
						hit = 1'b1;
						best = node;
					end
					lvl++;
				end
			end
			if (hit) begin
				res.found = 1'b1;
				res.route.prefix = node_pfx[best];
				res.route.length = node_len[best];
				res.route.tag = node_tag[best];
			end else if (dflt_valid) begin
				res.found = 1'b1;
				res.route.prefix = dflt_prefix;
				res.route.tag = dflt_tag;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		failures++;
		$display("%0t ns: response mismatch on %s, got %h, expected %h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_result_t want;
		if (!arst_n) begin
			next_free = 1;
			for (int i = 0; i < NODES; i++) begin
				zero_kid[i] = '0;
				one_kid[i] = '0;
				has_route[i] = 1'b0;
			end
			dflt_valid = 1'b0;
			pending_matches.delete();
			outstanding = 0;
			failures = 0;
		end else begin
			// the response leaving now belongs to an earlier request, so check it first
			if (rsp.valid && rsp.ready) begin
				if (pending_matches.size() == 0) begin
					report_mismatch("item with nothing pending", '0, '0);
				end else begin
					want = pending_matches.pop_front();
					if (rsp.found !== want.found)
						report_mismatch("found", FIELD_W'(rsp.found), FIELD_W'(want.found));
					if (rsp.matched_prefix !== want.route.prefix)
						report_mismatch("matched_prefix", rsp.matched_prefix, want.route.prefix);
					if (rsp.matched_length !== want.route.length)
						report_mismatch("matched_length", FIELD_W'(rsp.matched_length),
							FIELD_W'(want.route.length));
					if (rsp.matched_tag !== want.route.tag)
						report_mismatch("matched_tag", rsp.matched_tag, want.route.tag);
					if (rsp.pool_full !== want.pool_full)
						report_mismatch("pool_full", FIELD_W'(rsp.pool_full),
							FIELD_W'(want.pool_full));
				end
			end
			if (req.valid && req.ready)
				pending_matches.push_back(apply_route_op(opcode_t'(req.opcode),
					req.route_address, req.route_length, req.route_tag));
			outstanding = pending_matches.size();
		end
	end

endmodule

// ----- verif/binary_trie_longest_prefix_match_core_tb.sv -----
// testbench top for the trie route table: clock, reset, request and response traffic, verdict
`timescale 1ns / 100ps

module binary_trie_longest_prefix_match_core_tb;
	import btlpm_pkg::*;

	localparam int RANDOM_ITEMS    = 1830;
	localparam int DRAIN_CYCLES    = 40;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int KNOWN_MAX       = 400;
	localparam int TIMEOUT_NS      = 5_000_000;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	typedef struct {
		logic [FIELD_W-1:0] addr;
		logic [LEN_W-1:0]   len;
	} known_route_t;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;
	bit   hold_off_go;

	known_route_t       known_routes [$];
	logic [FIELD_W-1:0] family_base  [16];

	btlpm_req_if req_ch ();
	btlpm_rsp_if rsp_ch ();

	binary_trie_longest_prefix_match_core i_dut (
		.clk,
		.arst_n,
		.req (req_ch),
		.rsp (rsp_ch)
	);

	btlpm_route_checker i_checker (
		.clk,
		.arst_n,
		.req (req_ch),
		.rsp (rsp_ch),
		.failures,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("== FAIL ==");
		$finish;
	end

	// bits below the prefix length, free to vary without leaving the route
	function automatic logic [FIELD_W-1:0] low_bits(input logic [LEN_W-1:0] len);
		return (len >= FIELD_W) ? '0 : ({FIELD_W{1'b1}} >> len);
	endfunction

	// address sharing a random number of top bits with one of a few base addresses
	function automatic logic [FIELD_W-1:0] family_addr();
		logic [FIELD_W-1:0] hi_mask;
		hi_mask = {FIELD_W{1'b1}} << (FIELD_W - $urandom_range(4, 30));
		return (family_base[4'($urandom_range(0, 15))] & hi_mask) | ($urandom & ~hi_mask);
	endfunction

	task automatic send_item(input opcode_t op, input logic [FIELD_W-1:0] addr,
			input logic [LEN_W-1:0] len, input logic [FIELD_W-1:0] tag);
		known_route_t kr;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.route_address <= addr;
		req_ch.route_length <= len;
		req_ch.route_tag <= tag;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		if (op == OP_INSERT && len != 0 && known_routes.size() < KNOWN_MAX) begin
			kr.addr = addr;
			kr.len = len;
			known_routes.push_back(kr);
		end
	endtask

	// response side stalls on its own schedule, with one long hold-off
	initial begin
		rx_mode_t mode;
		int unsigned left, phase;
		bit hold_done;
		logic [7:0] stall_pattern;
		rsp_ch.ready <= 1'b0;
		hold_done = 1'b0;
		phase = 0;
		stall_pattern = 8'b1011_0010;
		forever begin
			if (hold_off_go && !hold_done) begin
				hold_done = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			left = $urandom_range(16, 160);
			repeat (left) begin
				@(negedge clk);
				case (mode)
					RX_ALWAYS: rsp_ch.ready <= 1'b1;
					RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						rsp_ch.ready <= stall_pattern[phase[2:0]];
						phase++;
					end
				endcase
			end
		end
	end

	initial begin
		int unsigned burst_left, r;
		known_route_t kr;
		opcode_t op;
		logic [FIELD_W-1:0] addr;
		logic [LEN_W-1:0] len;
		arst_n <= 1'b0;
		hold_off_go = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_LOOKUP;
		req_ch.route_address <= '0;
		req_ch.route_length <= '0;
		req_ch.route_tag <= '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, then the extremes of address, length and tag
		send_item(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0000_0000);
		send_item(OP_LOOKUP, 32'hffff_ffff, 6'd63, 32'hffff_ffff);
		send_item(OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000);
		send_item(OP_INSERT, 32'hffff_ffff, 6'd32, 32'hffff_ffff);
		send_item(OP_INSERT, 32'h8000_0000, 6'd1, 32'ha5a5_a5a5);
		// length above the address width saturates
		send_item(OP_INSERT, 32'h0a0b_0c0d, 6'd63, 32'h0000_0001);
		// prefix kept as given, bits below the length included
		send_item(OP_INSERT, 32'hc0a8_01ff, 6'd16, 32'h0000_0002);
		send_item(OP_INSERT, 32'hc0a8_0000, 6'd24, 32'h0000_0003);
		send_item(OP_LOOKUP, 32'hffff_ffff, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'hffff_fffe, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'h0000_0001, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'hc0a8_0077, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'hc0a8_ff00, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'h7fff_ffff, 6'd0, 32'h0);
		// default route, then replacements of a node route and of the default
		send_item(OP_INSERT, 32'h1234_5678, 6'd0, 32'hcafe_f00d);
		send_item(OP_LOOKUP, 32'h7fff_ffff, 6'd5, 32'h5555_5555);
		send_item(OP_INSERT, 32'hffff_ffff, 6'd1, 32'h0000_0005);
		send_item(OP_LOOKUP, 32'hbfff_ffff, 6'd0, 32'h0);
		send_item(OP_INSERT, 32'hffff_ffff, 6'd0, 32'h0000_0000);
		send_item(OP_LOOKUP, 32'h0a0b_0c0d, 6'd0, 32'h0);
		send_item(OP_LOOKUP, 32'h0000_0001, 6'd0, 32'h0);

		foreach (family_base[k])
			family_base[k] = $urandom;
		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				hold_off_go = 1'b1;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				// every third stretch of 150 items goes back to back
				if ((i / 150) % 3 != 2) begin
					@(negedge clk);
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(0, 7)) @(negedge clk);
				end
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (r < 45) begin
				op = OP_LOOKUP;
				len = LEN_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 45 && known_routes.size() > 0) begin
					kr = known_routes[$urandom_range(0, known_routes.size() - 1)];
					addr = kr.addr ^ ($urandom & low_bits(kr.len));
				end else if (r < 80) begin
					addr = family_addr();
				end else if (r < 88) begin
					addr = $urandom_range(0, 1) ? '1 : '0;
				end else begin
					addr = $urandom;
				end
			end else begin
				op = OP_INSERT;
				r = $urandom_range(0, 99);
				if (r < 25 && known_routes.size() > 0) begin
					// same node again, new tag and new bits below the length
					kr = known_routes[$urandom_range(0, known_routes.size() - 1)];
					addr = kr.addr ^ ($urandom & low_bits(kr.len));
					len = kr.len;
				end else begin
					addr = (r < 85) ? family_addr() : $urandom;
					r = $urandom_range(0, 99);
					if (r < 8)
						len = '0;
					else if (r < 16)
						len = LEN_W'($urandom_range(33, 63));
					else if (r < 24)
						len = LEN_W'(32);
					else
						len = LEN_W'($urandom_range(1, 31));
				end
			end
			send_item(op, addr, len, $urandom);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
